### hdl/tse_pkg.sv
// Shared types, constants and arithmetic helpers for the transient shaper.
package tse_pkg;

    // Sample rate the follower time constants are built for
    localparam longint unsigned SAMPLE_RATE_HZ = 48000;

    localparam longint unsigned Q30_ONE        = 64'd1 << 30;
    localparam int              MAX_MOD_Q8     = 4608;
    localparam int              DB_FLOOR_Q8    = -25600;
    localparam int              DB_PER_LOG2    = 394566;
    localparam int              LOG2_PER_DB    = 174165;
    localparam int              LN2_Q30        = 744261118;
    localparam logic [26:0]     GAIN_UNITY     = 27'd1048576;
    localparam int              EXP_TERMS      = 14;
    localparam int              LOG_STEPS      = 16;

    // Config register indexes
    typedef enum logic [2:0] {
        CFG_ENABLE    = 3'd0,
        CFG_PRE_GAIN  = 3'd1,
        CFG_POST_GAIN = 3'd2,
        CFG_ATTACK    = 3'd3,
        CFG_SUSTAIN   = 3'd4,
        CFG_CHARACTER = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic               enable;
        logic [23:0]        pre_gain;
        logic [23:0]        post_gain;
        logic signed [15:0] attack_amount;
        logic signed [15:0] sustain_amount;
        logic [1:0]         character;
    } t_cfg;

    typedef struct packed {
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
        logic [26:0]        gain_applied;
    } t_out_item;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE, S_PRE_A, S_PRE_B, S_PRE_C, S_PEAK,
        S_ENV_A, S_ENV_B, S_ENV_C,
        S_LOG_A, S_LOG_N, S_LOG_S, S_LOG_W, S_LOG_D, S_LOG_E,
        S_DIFF, S_WT_A, S_WT_B, S_WT_C,
        S_EXP_T, S_EXP_U, S_EXP_V, S_EXP_Y, S_EXP_M, S_EXP_D, S_EXP_W,
        S_GAIN_A, S_GAIN_B, S_OUT_A, S_OUT_B, S_OUT_C, S_FIN
    } t_state;

    // Datapath register updates
    typedef enum logic [4:0] {
        OP_NONE, OP_CAPTURE, OP_BYPASS, OP_P0, OP_P1, OP_PEAK,
        OP_LATCH_C, OP_ACC, OP_ENV, OP_LOG_INIT, OP_DB_FLOOR,
        OP_NORM_SHIFT, OP_M_LOAD, OP_SQ, OP_DB, OP_DIFF, OP_MOD,
        OP_T, OP_Y, OP_EXP_ACC, OP_GAIN, OP_OUT0, OP_OUT1, OP_LOAD_OUT
    } t_op;

    // Multiplier operand pairs
    typedef enum logic [3:0] {
        M_NONE, M_S0_PRE, M_S1_PRE, M_C_ENV, M_CC_PEAK, M_MM, M_L_DB,
        M_ATK, M_SUS, M_MOD_LOG, M_FRAC_LN2, M_MAG_Y, M_GMOD_POST,
        M_P0_GAIN, M_P1_GAIN
    } t_mul;

    typedef struct packed {
        t_op        op;
        t_mul       mul;
        logic [1:0] k;
        logic [3:0] n;
        logic       div_start;
    } t_cmd;

    typedef struct packed {
        logic env_zero;
        logic norm_top;
        logic div_done;
        logic out_free;
    } t_sts;

    // Round half away from zero, then shift right
    function automatic logic signed [65:0] rshr(input logic signed [65:0] v,
                                                input int unsigned sh);
        logic [65:0] mag;
        logic [65:0] half;
        half = 66'd1 << (sh - 1);
        if (v < 0) begin
            mag  = 66'(-v);
            rshr = -$signed((mag + half) >> sh);
        end else begin
            rshr = $signed(($unsigned(v) + half) >> sh);
        end
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [65:0] v);
        if (v > 66'sd8388607) begin
            sat24 = 24'sh7FFFFF;
        end else if (v < -66'sd8388608) begin
            sat24 = 24'sh800000;
        end else begin
            sat24 = v[23:0];
        end
    endfunction

    // exp(-x) by series, Q30 in, Q0.24 out; build time only
    function automatic logic [23:0] coef_calc(input longint unsigned x);
        longint unsigned xx;
        longint unsigned sum;
        longint unsigned mag;
        longint unsigned c;
        xx  = (x > Q30_ONE) ? Q30_ONE : x;
        sum = Q30_ONE;
        mag = Q30_ONE;
        mag = ((mag * xx) >> 30) / 1;  sum = sum - mag;
        mag = ((mag * xx) >> 30) / 2;  sum = sum + mag;
        mag = ((mag * xx) >> 30) / 3;  sum = sum - mag;
        mag = ((mag * xx) >> 30) / 4;  sum = sum + mag;
        mag = ((mag * xx) >> 30) / 5;  sum = sum - mag;
        mag = ((mag * xx) >> 30) / 6;  sum = sum + mag;
        mag = ((mag * xx) >> 30) / 7;  sum = sum - mag;
        mag = ((mag * xx) >> 30) / 8;  sum = sum + mag;
        mag = ((mag * xx) >> 30) / 9;  sum = sum - mag;
        mag = ((mag * xx) >> 30) / 10; sum = sum + mag;
        mag = ((mag * xx) >> 30) / 11; sum = sum - mag;
        mag = ((mag * xx) >> 30) / 12; sum = sum + mag;
        mag = ((mag * xx) >> 30) / 13; sum = sum - mag;
        mag = ((mag * xx) >> 30) / 14; sum = sum + mag;
        c = (sum + 64'd32) >> 6;
        coef_calc = (c > 64'hFFFFFF) ? 24'hFFFFFF : c[23:0];
    endfunction

    // Time constants in 0.1 ms, six per character:
    // fast attack, slow attack, shared release, shared attack, fast release, slow release
    localparam longint unsigned TENTH_MS [18] = '{
        15, 400, 4000, 30, 1200, 5000,
        5,  250, 2500, 10, 600,  3500,
        2,  150, 1500, 5,  300,  2000
    };

    localparam longint unsigned DEN [18] = '{
        TENTH_MS[0] * SAMPLE_RATE_HZ,  TENTH_MS[1] * SAMPLE_RATE_HZ,
        TENTH_MS[2] * SAMPLE_RATE_HZ,  TENTH_MS[3] * SAMPLE_RATE_HZ,
        TENTH_MS[4] * SAMPLE_RATE_HZ,  TENTH_MS[5] * SAMPLE_RATE_HZ,
        TENTH_MS[6] * SAMPLE_RATE_HZ,  TENTH_MS[7] * SAMPLE_RATE_HZ,
        TENTH_MS[8] * SAMPLE_RATE_HZ,  TENTH_MS[9] * SAMPLE_RATE_HZ,
        TENTH_MS[10] * SAMPLE_RATE_HZ, TENTH_MS[11] * SAMPLE_RATE_HZ,
        TENTH_MS[12] * SAMPLE_RATE_HZ, TENTH_MS[13] * SAMPLE_RATE_HZ,
        TENTH_MS[14] * SAMPLE_RATE_HZ, TENTH_MS[15] * SAMPLE_RATE_HZ,
        TENTH_MS[16] * SAMPLE_RATE_HZ, TENTH_MS[17] * SAMPLE_RATE_HZ
    };

    localparam longint unsigned XNUM = 64'd10000 << 30;

    localparam longint unsigned COEF_X [18] = '{
        (XNUM + DEN[0] / 2) / DEN[0],   (XNUM + DEN[1] / 2) / DEN[1],
        (XNUM + DEN[2] / 2) / DEN[2],   (XNUM + DEN[3] / 2) / DEN[3],
        (XNUM + DEN[4] / 2) / DEN[4],   (XNUM + DEN[5] / 2) / DEN[5],
        (XNUM + DEN[6] / 2) / DEN[6],   (XNUM + DEN[7] / 2) / DEN[7],
        (XNUM + DEN[8] / 2) / DEN[8],   (XNUM + DEN[9] / 2) / DEN[9],
        (XNUM + DEN[10] / 2) / DEN[10], (XNUM + DEN[11] / 2) / DEN[11],
        (XNUM + DEN[12] / 2) / DEN[12], (XNUM + DEN[13] / 2) / DEN[13],
        (XNUM + DEN[14] / 2) / DEN[14], (XNUM + DEN[15] / 2) / DEN[15],
        (XNUM + DEN[16] / 2) / DEN[16], (XNUM + DEN[17] / 2) / DEN[17]
    };

    localparam logic [23:0] COEF_TAB [18] = '{
        coef_calc(COEF_X[0]),  coef_calc(COEF_X[1]),  coef_calc(COEF_X[2]),
        coef_calc(COEF_X[3]),  coef_calc(COEF_X[4]),  coef_calc(COEF_X[5]),
        coef_calc(COEF_X[6]),  coef_calc(COEF_X[7]),  coef_calc(COEF_X[8]),
        coef_calc(COEF_X[9]),  coef_calc(COEF_X[10]), coef_calc(COEF_X[11]),
        coef_calc(COEF_X[12]), coef_calc(COEF_X[13]), coef_calc(COEF_X[14]),
        coef_calc(COEF_X[15]), coef_calc(COEF_X[16]), coef_calc(COEF_X[17])
    };

endpackage

### hdl/tse_cfg.sv
// Configuration register file of the transient shaper.
module tse_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    output tse_pkg::t_cfg      o_cfg
);
    import tse_pkg::*;

    t_cfg r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable         <= 1'b0;
            r_cfg.pre_gain       <= 24'd1048576;
            r_cfg.post_gain      <= 24'd1048576;
            r_cfg.attack_amount  <= 16'sd0;
            r_cfg.sustain_amount <= 16'sd0;
            r_cfg.character      <= 2'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE:    r_cfg.enable         <= i_cfg_data[0];
                CFG_PRE_GAIN:  r_cfg.pre_gain       <= i_cfg_data;
                CFG_POST_GAIN: r_cfg.post_gain      <= i_cfg_data;
                CFG_ATTACK:    r_cfg.attack_amount  <= i_cfg_data[15:0];
                CFG_SUSTAIN:   r_cfg.sustain_amount <= i_cfg_data[15:0];
                CFG_CHARACTER: r_cfg.character      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/tse_div.sv
// Small-divisor long divider, eight quotient bits per cycle.
module tse_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [3:0]  i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);
    import tse_pkg::*;

    logic [31:0] r_dvd;
    logic [31:0] r_quo;
    logic [3:0]  r_rem;
    logic [3:0]  r_dsr;
    logic [1:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [4:0]  step_rem;
    logic [7:0]  step_q;

    // Eight restoring steps on the top dividend byte
    always_comb begin
        step_rem = {1'b0, r_rem};
        step_q   = 8'd0;
        for (int j = 0; j < 8; j++) begin
            step_rem = {step_rem[3:0], r_dvd[31 - j]};
            if (step_rem >= {1'b0, r_dsr}) begin
                step_rem      = step_rem - {1'b0, r_dsr};
                step_q[7 - j] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else if (i_start) begin
            r_dvd  <= i_dividend;
            r_dsr  <= i_divisor;
            r_rem  <= 4'd0;
            r_cnt  <= 2'd0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 8;
            r_quo <= {r_quo[23:0], step_q};
            r_rem <= step_rem[3:0];
            r_cnt <= r_cnt + 2'd1;
            if (r_cnt == 2'd3) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### hdl/tse_ctrl.sv
// Sequencer that steps the shared multiplier datapath through one frame.
module tse_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_enable,
    input  tse_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output tse_pkg::t_cmd  o_cmd
);
    import tse_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;
    logic [3:0] r_i, n_i;
    logic [3:0] r_n, n_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 2'd0;
            r_i     <= 4'd0;
            r_n     <= 4'd1;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_n     <= n_n;
        end
    end

    // Next state and loop counters
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        n_n     = r_n;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_enable ? S_PRE_A : S_FIN;
                end
            end
            S_PRE_A: n_state = S_PRE_B;
            S_PRE_B: n_state = S_PRE_C;
            S_PRE_C: n_state = S_PEAK;
            S_PEAK: begin
                n_k     = 2'd0;
                n_state = S_ENV_A;
            end
            S_ENV_A: n_state = S_ENV_B;
            S_ENV_B: n_state = S_ENV_C;
            S_ENV_C: begin
                n_k     = r_k + 2'd1;
                n_state = (r_k == 2'd3) ? S_LOG_A : S_ENV_A;
            end
            S_LOG_A: begin
                if (i_sts.env_zero) begin
                    n_k     = r_k + 2'd1;
                    n_state = (r_k == 2'd3) ? S_DIFF : S_LOG_A;
                end else begin
                    n_state = S_LOG_N;
                end
            end
            S_LOG_N: begin
                if (i_sts.norm_top) begin
                    n_i     = 4'd0;
                    n_state = S_LOG_S;
                end
            end
            S_LOG_S: n_state = S_LOG_W;
            S_LOG_W: begin
                n_i     = r_i + 4'd1;
                n_state = (r_i == 4'(LOG_STEPS - 1)) ? S_LOG_D : S_LOG_S;
            end
            S_LOG_D: n_state = S_LOG_E;
            S_LOG_E: begin
                n_k     = r_k + 2'd1;
                n_state = (r_k == 2'd3) ? S_DIFF : S_LOG_A;
            end
            S_DIFF:  n_state = S_WT_A;
            S_WT_A:  n_state = S_WT_B;
            S_WT_B:  n_state = S_WT_C;
            S_WT_C:  n_state = S_EXP_T;
            S_EXP_T: n_state = S_EXP_U;
            S_EXP_U: n_state = S_EXP_V;
            S_EXP_V: n_state = S_EXP_Y;
            S_EXP_Y: begin
                n_n     = 4'd1;
                n_state = S_EXP_M;
            end
            S_EXP_M: n_state = S_EXP_D;
            S_EXP_D: n_state = S_EXP_W;
            S_EXP_W: begin
                if (i_sts.div_done) begin
                    n_n     = r_n + 4'd1;
                    n_state = (r_n == 4'(EXP_TERMS)) ? S_GAIN_A : S_EXP_M;
                end
            end
            S_GAIN_A: n_state = S_GAIN_B;
            S_GAIN_B: n_state = S_OUT_A;
            S_OUT_A:  n_state = S_OUT_B;
            S_OUT_B:  n_state = S_OUT_C;
            S_OUT_C:  n_state = S_FIN;
            S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.op        = OP_NONE;
        o_cmd.mul       = M_NONE;
        o_cmd.k         = r_k;
        o_cmd.n         = r_n;
        o_cmd.div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = i_enable ? OP_CAPTURE : OP_BYPASS;
                end
            end
            S_PRE_A: o_cmd.mul = M_S0_PRE;
            S_PRE_B: begin
                o_cmd.op  = OP_P0;
                o_cmd.mul = M_S1_PRE;
            end
            S_PRE_C: o_cmd.op = OP_P1;
            S_PEAK:  o_cmd.op = OP_PEAK;
            S_ENV_A: begin
                o_cmd.op  = OP_LATCH_C;
                o_cmd.mul = M_C_ENV;
            end
            S_ENV_B: begin
                o_cmd.op  = OP_ACC;
                o_cmd.mul = M_CC_PEAK;
            end
            S_ENV_C: o_cmd.op = OP_ENV;
            S_LOG_A: o_cmd.op = i_sts.env_zero ? OP_DB_FLOOR : OP_LOG_INIT;
            S_LOG_N: o_cmd.op = i_sts.norm_top ? OP_M_LOAD : OP_NORM_SHIFT;
            S_LOG_S: o_cmd.mul = M_MM;
            S_LOG_W: o_cmd.op = OP_SQ;
            S_LOG_D: o_cmd.mul = M_L_DB;
            S_LOG_E: o_cmd.op = OP_DB;
            S_DIFF:  o_cmd.op = OP_DIFF;
            S_WT_A:  o_cmd.mul = M_ATK;
            S_WT_B: begin
                o_cmd.op  = OP_ACC;
                o_cmd.mul = M_SUS;
            end
            S_WT_C:  o_cmd.op = OP_MOD;
            S_EXP_T: o_cmd.mul = M_MOD_LOG;
            S_EXP_U: o_cmd.op = OP_T;
            S_EXP_V: o_cmd.mul = M_FRAC_LN2;
            S_EXP_Y: o_cmd.op = OP_Y;
            S_EXP_M: o_cmd.mul = M_MAG_Y;
            S_EXP_D: o_cmd.div_start = 1'b1;
            S_EXP_W: o_cmd.op = i_sts.div_done ? OP_EXP_ACC : OP_NONE;
            S_GAIN_A: o_cmd.mul = M_GMOD_POST;
            S_GAIN_B: o_cmd.op = OP_GAIN;
            S_OUT_A:  o_cmd.mul = M_P0_GAIN;
            S_OUT_B: begin
                o_cmd.op  = OP_OUT0;
                o_cmd.mul = M_P1_GAIN;
            end
            S_OUT_C: o_cmd.op = OP_OUT1;
            S_FIN:   o_cmd.op = i_sts.out_free ? OP_LOAD_OUT : OP_NONE;
            default: ;
        endcase
    end

`ifndef SYNTH
    // A bypassed frame goes straight to the output stage
    a_bypass_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && !i_enable) |=> r_state == S_FIN)
        else $error("bypass frame did not reach output stage");
    // The exponential loop only leaves after the divider finished
    a_exp_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP_W && !i_sts.div_done) |=> r_state == S_EXP_W)
        else $error("series step left before divide finished");
    // The squaring loop runs its full length
    a_log_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOG_D) |-> $past(r_i) == 4'(LOG_STEPS - 1))
        else $error("log2 loop ran short");
`endif

endmodule

### hdl/tse_dp.sv
// Datapath: shared multiplier, follower state, log2/exp working registers.
module tse_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tse_pkg::t_cmd       i_cmd,
    input  tse_pkg::t_cfg       i_cfg,
    input  tse_pkg::t_in_item   i_in_data,
    input  logic                i_out_ready,
    output tse_pkg::t_sts       o_sts,
    output logic                o_out_valid,
    output tse_pkg::t_out_item  o_out_data
);
    import tse_pkg::*;

    logic signed [23:0] r_s0, r_s1;
    logic signed [27:0] r_p0, r_p1;
    logic [27:0]        r_peak;
    logic [27:0]        r_env [4];
    logic [23:0]        r_c;
    logic signed [52:0] r_acc;
    logic [27:0]        r_norm;
    logic [4:0]         r_e;
    logic [30:0]        r_m;
    logic [15:0]        r_frac;
    logic signed [15:0] r_db [4];
    logic [12:0]        r_ad, r_sd;
    logic signed [13:0] r_mod;
    logic [2:0]         r_ip;
    logic [27:0]        r_f28;
    logic [29:0]        r_y;
    logic [31:0]        r_sum;
    logic [30:0]        r_mag;
    logic [26:0]        r_gain;
    logic signed [23:0] r_lo, r_ro;
    logic signed [65:0] r_prod;
    logic               r_out_valid;
    t_out_item          r_out;

    logic signed [32:0] mul_a, mul_b;
    logic [27:0]        env_k;
    logic               up;
    logic [1:0]         ch_eff;
    logic [2:0]         sel;
    logic [4:0]         coef_idx;
    logic [23:0]        coef_now;
    logic signed [21:0] l_val;
    logic [31:0]        gmod;
    logic signed [65:0] env_sum, g_sum, t_val, w_sum, rnd_v;
    logic [27:0]        abs0, abs1;
    logic signed [16:0] ad_raw, sd_raw;
    logic               div_done;
    logic [31:0]        div_quot;

    function automatic logic [12:0] clamp_diff(input logic signed [16:0] d);
        if (d < 0) begin
            clamp_diff = 13'd0;
        end else if (d > 17'(MAX_MOD_Q8)) begin
            clamp_diff = 13'(MAX_MOD_Q8);
        end else begin
            clamp_diff = d[12:0];
        end
    endfunction

    // Follower coefficient: attack when the peak rises above the follower
    assign env_k  = r_env[i_cmd.k];
    assign up     = r_peak > env_k;
    assign ch_eff = (i_cfg.character == 2'd3) ? 2'd2 : i_cfg.character;
    always_comb begin
        case (i_cmd.k)
            2'd0:    sel = up ? 3'd0 : 3'd2;
            2'd1:    sel = up ? 3'd1 : 3'd2;
            2'd2:    sel = up ? 3'd3 : 3'd4;
            default: sel = up ? 3'd3 : 3'd5;
        endcase
    end
    assign coef_idx = 5'(ch_eff) * 5'd6 + 5'(sel);
    assign coef_now = COEF_TAB[coef_idx];

    // Log2 relative to full scale, and the exponent alignment for the gain
    assign l_val = $signed({1'b0, r_e, r_frac}) - 22'sd1507328;
    assign gmod  = (r_sum + (32'd1 << (4'd12 - 4'(r_ip)))) >> (4'd13 - 4'(r_ip));

    assign abs0    = (r_p0 < 0) ? 28'(-r_p0) : 28'(r_p0);
    assign abs1    = (r_p1 < 0) ? 28'(-r_p1) : 28'(r_p1);
    assign ad_raw  = 17'(r_db[0]) - 17'(r_db[1]);
    assign sd_raw  = 17'(r_db[3]) - 17'(r_db[2]);
    assign env_sum = 66'(r_acc) + r_prod + 66'sd8388608;
    assign g_sum   = r_prod + 66'sd524288;
    assign t_val   = r_prod + 66'sd805306368;
    assign w_sum   = 66'(r_acc) + r_prod;

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
        case (i_cmd.mul)
            M_S0_PRE: begin
                mul_a = 33'(r_s0);
                mul_b = $signed({9'd0, i_cfg.pre_gain});
            end
            M_S1_PRE: begin
                mul_a = 33'(r_s1);
                mul_b = $signed({9'd0, i_cfg.pre_gain});
            end
            M_C_ENV: begin
                mul_a = $signed({9'd0, coef_now});
                mul_b = $signed({5'd0, env_k});
            end
            M_CC_PEAK: begin
                mul_a = $signed(33'h1000000 - {9'd0, r_c});
                mul_b = $signed({5'd0, r_peak});
            end
            M_MM: begin
                mul_a = $signed({2'd0, r_m});
                mul_b = $signed({2'd0, r_m});
            end
            M_L_DB: begin
                mul_a = 33'(l_val);
                mul_b = 33'sd394566;
            end
            M_ATK: begin
                mul_a = 33'(i_cfg.attack_amount);
                mul_b = $signed({20'd0, r_ad});
            end
            M_SUS: begin
                mul_a = 33'(i_cfg.sustain_amount);
                mul_b = $signed({20'd0, r_sd});
            end
            M_MOD_LOG: begin
                mul_a = 33'(r_mod);
                mul_b = 33'sd174165;
            end
            M_FRAC_LN2: begin
                mul_a = $signed({5'd0, r_f28});
                mul_b = 33'sd744261118;
            end
            M_MAG_Y: begin
                mul_a = $signed({2'd0, r_mag});
                mul_b = $signed({3'd0, r_y});
            end
            M_GMOD_POST: begin
                mul_a = $signed({1'b0, gmod});
                mul_b = $signed({9'd0, i_cfg.post_gain});
            end
            M_P0_GAIN: begin
                mul_a = 33'(r_p0);
                mul_b = $signed({6'd0, r_gain});
            end
            M_P1_GAIN: begin
                mul_a = 33'(r_p1);
                mul_b = $signed({6'd0, r_gain});
            end
            default: ;
        endcase
    end

    // Rounded shift of the product (of accumulator plus product for OP_MOD) for the ops that need one
    always_comb begin
        case (i_cmd.op)
            OP_DB:   rnd_v = rshr(r_prod, 24);
            OP_MOD:  rnd_v = rshr(w_sum, 15);
            default: rnd_v = rshr(r_prod, 20);
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    tse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod[61:30]),
        .i_divisor  (i_cmd.n),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Follower state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) begin
                r_env[j] <= 28'd0;
            end
        end else if (i_cmd.op == OP_ENV) begin
            r_env[i_cmd.k] <= env_sum[51:24];
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_s0 <= i_in_data.left_sample;
                r_s1 <= i_in_data.right_sample;
            end
            OP_BYPASS: begin
                r_lo   <= i_in_data.left_sample;
                r_ro   <= i_in_data.right_sample;
                r_gain <= GAIN_UNITY;
            end
            OP_P0:      r_p0 <= rnd_v[27:0];
            OP_P1:      r_p1 <= rnd_v[27:0];
            OP_PEAK:    r_peak <= (abs0 > abs1) ? abs0 : abs1;
            OP_LATCH_C: r_c <= coef_now;
            OP_ACC:     r_acc <= r_prod[52:0];
            OP_LOG_INIT: begin
                r_norm <= env_k;
                r_e    <= 5'd27;
                r_frac <= 16'd0;
            end
            OP_DB_FLOOR: r_db[i_cmd.k] <= 16'(DB_FLOOR_Q8);
            OP_NORM_SHIFT: begin
                r_norm <= r_norm << 1;
                r_e    <= r_e - 5'd1;
            end
            OP_M_LOAD: r_m <= {r_norm, 3'd0};
            OP_SQ: begin
                r_frac <= {r_frac[14:0], r_prod[61]};
                r_m    <= r_prod[61] ? r_prod[61:31] : r_prod[60:30];
            end
            OP_DB: begin
                if (rnd_v < 66'(DB_FLOOR_Q8)) begin
                    r_db[i_cmd.k] <= 16'(DB_FLOOR_Q8);
                end else begin
                    r_db[i_cmd.k] <= rnd_v[15:0];
                end
            end
            OP_DIFF: begin
                r_ad <= clamp_diff(ad_raw);
                r_sd <= clamp_diff(sd_raw);
            end
            OP_MOD: begin
                if (rnd_v > 66'(MAX_MOD_Q8)) begin
                    r_mod <= 14'(MAX_MOD_Q8);
                end else if (rnd_v < -66'(MAX_MOD_Q8)) begin
                    r_mod <= -14'(MAX_MOD_Q8);
                end else begin
                    r_mod <= rnd_v[13:0];
                end
            end
            OP_T: begin
                r_ip  <= t_val[30:28];
                r_f28 <= t_val[27:0];
            end
            OP_Y: begin
                r_y   <= r_prod[57:28];
                r_sum <= 32'(Q30_ONE);
                r_mag <= 31'(Q30_ONE);
            end
            OP_EXP_ACC: begin
                r_mag <= div_quot[30:0];
                r_sum <= r_sum + div_quot;
            end
            OP_GAIN: r_gain <= g_sum[46:20];
            OP_OUT0: r_lo <= sat24(rnd_v);
            OP_OUT1: r_ro <= sat24(rnd_v);
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_LOAD_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD_OUT) begin
            r_out.left_out     <= r_lo;
            r_out.right_out    <= r_ro;
            r_out.gain_applied <= r_gain;
        end
    end

    assign o_sts.env_zero = (env_k == 28'd0);
    assign o_sts.norm_top = r_norm[27];
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

`ifndef SYNTH
    // Never overwrite a result that is still waiting
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_LOAD_OUT) |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before transfer");
    // Squaring input stays normalized to [1, 2)
    a_m_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mul == M_MM) |-> r_m[30])
        else $error("log2 mantissa not normalized");
    // Bypassed frames carry unity gain
    a_bypass_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_BYPASS) |=> r_gain == GAIN_UNITY)
        else $error("bypass gain not unity");
`endif

endmodule

### hdl/transient_shaper_envelope_gain.sv
// Transient shaper top level: config registers, sequencer and datapath.
//
// Usage: stereo frames enter on the i_in_* channel (valid/ready) and one
// result per frame leaves on the o_out_* channel (valid/ready): both samples
// scaled by the computed gain, saturated to 24 bits, plus the gain itself.
// Registers are written on the i_cfg_* channel (index, data), always ready;
// write them only while no frame is in flight.
// An enabled frame passes the log2 squaring loop (16 products per follower
// plus up to 27 normalize shifts) and the 14-term exponential series, all on
// one shared multiplier; each series term waits on the four-step divider.
// A disabled frame goes from its transfer straight to the output stage.
// Frames are handled one at a time; the next frame is taken once the current
// one is parked in the output register.
// Reset (i_rst_n low, synchronous) clears the four followers, the sequencer
// and the output valid, and loads register defaults (disabled, unity gains).
// When the receiver stalls, the result holds in the output register, and
// the block finishes one more frame and then waits before loading it.
module transient_shaper_envelope_gain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tse_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tse_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);
    import tse_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    tse_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_enable   (cfg.enable),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    tse_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### tb/tb.sv
// Self-checking testbench for the transient shaper envelope gain block.
`timescale 1ns / 1ps

module tb;
    import tse_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       o_in_ready;
    t_in_item   in_data;
    logic       o_out_valid;
    logic       out_ready;
    t_out_item  o_out_data;
    logic       cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] cfg_index;
    logic [23:0] cfg_data;

    transient_shaper_envelope_gain u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Follower time constants in 0.1 ms per character:
    // fast attack, slow attack, shared release, shared attack, fast release, slow release
    localparam longint unsigned TC_TENTHS [18] = '{
        15, 400, 4000, 30, 1200, 5000,
        5,  250, 2500, 10, 600,  3500,
        2,  150, 1500, 5,  300,  2000
    };
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    // Shadow of the configuration and follower state
    logic                sh_enable;
    logic [23:0]         sh_pre_gain;
    logic [23:0]         sh_post_gain;
    logic signed [15:0]  sh_attack;
    logic signed [15:0]  sh_sustain;
    logic [1:0]          sh_character;
    longint unsigned     env_fa, env_sa, env_fr, env_sr;

    t_in_item  pending_frames[$];
    t_out_item expected_frames[$];
    int        mismatches;
    bit        burst_mode;
    int        hold_request;
    int        send_gap;
    int        recv_stall;
    int        recv_hold;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint rnd_shift(longint v, int sh);
        longint unsigned half;
        longint unsigned mag;
        half = 64'd1 << (sh - 1);
        if (v < 0) begin
            mag = longint'(0) - v;
            return -longint'((mag + half) >> sh);
        end
        return longint'((longint'(v) + half) >> sh);
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // Taylor series for exp(x) or exp(-x), Q30
    function automatic longint unsigned exp_series(longint unsigned x, bit neg);
        longint unsigned acc;
        longint unsigned term;
        acc  = ONE_Q30;
        term = ONE_Q30;
        for (int n = 1; n <= 14; n++) begin
            term = ((term * x) >> 30) / n;
            if (neg && (n % 2 == 1)) acc = acc - term;
            else acc = acc + term;
        end
        return acc;
    endfunction

    function automatic longint unsigned pole_coef(int sel);
        int ch;
        longint unsigned den;
        longint unsigned x;
        longint unsigned c;
        ch  = (sh_character > 2) ? 2 : int'(sh_character);
        den = TC_TENTHS[ch * 6 + sel] * SAMPLE_RATE_HZ;
        x   = ((64'd10000 << 30) + den / 2) / den;
        if (x > ONE_Q30) x = ONE_Q30;
        c = (exp_series(x, 1'b1) + 32) >> 6;
        if (c > 64'hFFFFFF) c = 64'hFFFFFF;
        return c;
    endfunction

    function automatic longint unsigned track(longint unsigned env, longint unsigned peak,
                                              int up_sel, int down_sel);
        longint unsigned c;
        c = pole_coef(peak > env ? up_sel : down_sel);
        return ((c * env + ((64'd1 << 24) - c) * peak + (64'd1 << 23)) >> 24) & 64'hFFFFFFF;
    endfunction

    // Follower level in dB, Q8.8, with the silent floor
    function automatic longint level_db(longint unsigned env);
        int e;
        longint unsigned m;
        longint unsigned frac;
        longint l;
        longint db;
        if (env == 0) return DB_FLOOR_Q8;
        e = 27;
        frac = 0;
        while (((env >> e) & 1) == 0) e--;
        m = env << (30 - e);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        l  = longint'((longint'(e) << 16) | frac) - (longint'(23) << 16);
        db = rnd_shift(l * DB_PER_LOG2, 24);
        return (db < DB_FLOOR_Q8) ? DB_FLOOR_Q8 : db;
    endfunction

    function automatic longint clamp_mod(longint v);
        if (v > MAX_MOD_Q8) return MAX_MOD_Q8;
        if (v < -MAX_MOD_Q8) return -MAX_MOD_Q8;
        return v;
    endfunction

    // Gain computation for one frame; advances the followers
    function automatic t_out_item shape_frame(t_in_item f);
        t_out_item r;
        longint s0, s1, p0, p1, ad, sd, md, t;
        longint unsigned a0, a1, peak, ip, frac, y, gmod, gain;
        s0 = f.left_sample;
        s1 = f.right_sample;
        if (!sh_enable) begin
            r.left_out     = f.left_sample;
            r.right_out    = f.right_sample;
            r.gain_applied = 27'd1048576;
            return r;
        end
        p0 = rnd_shift(s0 * longint'(sh_pre_gain), 20);
        p1 = rnd_shift(s1 * longint'(sh_pre_gain), 20);
        a0 = (p0 < 0) ? -p0 : p0;
        a1 = (p1 < 0) ? -p1 : p1;
        peak = (a0 > a1) ? a0 : a1;
        env_fa = track(env_fa, peak, 0, 2);
        env_sa = track(env_sa, peak, 1, 2);
        env_fr = track(env_fr, peak, 3, 4);
        env_sr = track(env_sr, peak, 3, 5);
        ad = level_db(env_fa) - level_db(env_sa);
        sd = level_db(env_sr) - level_db(env_fr);
        if (ad < 0) ad = 0;
        if (ad > MAX_MOD_Q8) ad = MAX_MOD_Q8;
        if (sd < 0) sd = 0;
        if (sd > MAX_MOD_Q8) sd = MAX_MOD_Q8;
        md = clamp_mod(rnd_shift(longint'(sh_attack) * ad + longint'(sh_sustain) * sd, 15));
        t    = md * LOG2_PER_DB + (longint'(3) << 28);
        ip   = longint'(t) >> 28;
        frac = longint'(t) & ((64'd1 << 28) - 1);
        y    = (frac * LN2_Q30) >> 28;
        gmod = exp_series(y, 1'b0);
        gmod = (gmod + (64'd1 << (12 - ip))) >> (13 - ip);
        gain = ((gmod * longint'(sh_post_gain) + (64'd1 << 19)) >> 20) & 64'h7FFFFFF;
        r.left_out     = 24'(clip24(rnd_shift(p0 * longint'(gain), 20)));
        r.right_out    = 24'(clip24(rnd_shift(p1 * longint'(gain), 20)));
        r.gain_applied = gain[26:0];
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Input driver: takes frames from the pending queue with random gaps outside burst mode
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_frames.insert(expected_frames.size(), shape_frame(in_data));
            end
            if (!in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_frames.size() > 0) begin
                    in_data  <= pending_frames.pop_front();
                    in_valid <= 1'b1;
                    send_gap = burst_mode ? 0 : $urandom_range(0, 16);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: random stalls outside burst mode, plus long holds on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            recv_stall = 0;
            recv_hold  = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_frames.size() == 0) begin
                    flag_mismatch("result transfer with nothing expected", 1, 0);
                end else begin
                    t_out_item want;
                    want = expected_frames.pop_front();
                    if (o_out_data.left_out !== want.left_out)
                        flag_mismatch("left_out", o_out_data.left_out, want.left_out);
                    if (o_out_data.right_out !== want.right_out)
                        flag_mismatch("right_out", o_out_data.right_out, want.right_out);
                    if (o_out_data.gain_applied !== want.gain_applied)
                        flag_mismatch("gain_applied", o_out_data.gain_applied,
                                      want.gain_applied);
                end
                recv_stall = burst_mode ? 0 : $urandom_range(0, 16);
            end
            if (hold_request > 0) begin
                recv_hold = hold_request;
                hold_request = 0;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                out_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // One register write; shadow updated at the transfer
    task automatic write_reg(t_cfg_idx idx, logic [23:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ENABLE:    sh_enable    = value[0];
            CFG_PRE_GAIN:  sh_pre_gain  = value;
            CFG_POST_GAIN: sh_post_gain = value;
            CFG_ATTACK:    sh_attack    = value[15:0];
            CFG_SUSTAIN:   sh_sustain   = value[15:0];
            CFG_CHARACTER: sh_character = value[1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic en, logic [23:0] pre, logic [23:0] post,
                             logic [15:0] atk, logic [15:0] sus, logic [1:0] chr);
        write_reg(CFG_ENABLE, {23'd0, en});
        write_reg(CFG_PRE_GAIN, pre);
        write_reg(CFG_POST_GAIN, post);
        write_reg(CFG_ATTACK, {8'd0, atk});
        write_reg(CFG_SUSTAIN, {8'd0, sus});
        write_reg(CFG_CHARACTER, {22'd0, chr});
    endtask

    task automatic push_frame(longint l, longint r);
        t_in_item f;
        f.left_sample  = l[23:0];
        f.right_sample = r[23:0];
        pending_frames.insert(pending_frames.size(), f);
    endtask

    // Wait for the block to drain, then a short settle
    task automatic drain();
        while (pending_frames.size() > 0 || in_valid || expected_frames.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'd1048576;
            3: return 24'($urandom_range(0, 2097152));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_amount();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h8001;
            3: return 16'd0;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random frames: mostly runs at a random level, mixed with full-range random and extreme samples
    task automatic random_frames(int count);
        longint amp;
        longint l, r;
        int run;
        run = 0;
        amp = 0;
        for (int i = 0; i < count; i++) begin
            if (run == 0) begin
                run = $urandom_range(1, 60);
                case ($urandom_range(0, 3))
                    0: amp = 0;
                    1: amp = $urandom_range(0, 2000);
                    2: amp = $urandom_range(0, 300000);
                    default: amp = $urandom_range(1000000, 8388607);
                endcase
            end
            run--;
            case ($urandom_range(0, 7))
                0, 1: begin
                    l = $signed(24'($urandom));
                    r = $signed(24'($urandom));
                end
                2: begin
                    l = $urandom_range(0, 1) ? 8388607 : -8388608;
                    r = $urandom_range(0, 1) ? -8388608 : 0;
                end
                default: begin
                    l = $urandom_range(0, 32'(amp));
                    r = $urandom_range(0, 32'(amp));
                    if ($urandom_range(0, 1)) l = -l;
                    if ($urandom_range(0, 1)) r = -r;
                end
            endcase
            push_frame(l, r);
        end
    endtask

    // Stimulus sequence
    initial begin
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_ENABLE;
        cfg_data   = '0;
        mismatches = 0;
        burst_mode = 1'b0;
        hold_request = 0;
        sh_enable    = 1'b0;
        sh_pre_gain  = 24'd1048576;
        sh_post_gain = 24'd1048576;
        sh_attack    = '0;
        sh_sustain   = '0;
        sh_character = 2'd1;
        env_fa = 0; env_sa = 0; env_fr = 0; env_sr = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Pass-through at reset defaults
        push_frame(8388607, -8388608);
        push_frame(-8388608, 8388607);
        push_frame(0, -1);
        drain();

        // Strong attack and sustain, hard character: burst then silence
        write_all(1'b1, 24'd1048576, 24'd1048576, 16'h7FFF, 16'h8000, 2'd2);
        push_frame(0, 0);
        push_frame(8388607, 8388607);
        push_frame(-8388608, -8388608);
        push_frame(8388607, -8388608);
        push_frame(1, -1);
        for (int i = 0; i < 6; i++) push_frame(0, 0);
        drain();

        // Maximum pre-gain and make-up, character three, negative attack
        write_all(1'b1, 24'hFFFFFF, 24'hFFFFFF, 16'h8000, 16'h7FFF, 2'd3);
        push_frame(8388607, 0);
        push_frame(-8388608, 100);
        push_frame(4000, -4000);
        push_frame(0, 0);
        drain();

        // Zero gains, soft character
        write_all(1'b1, 24'd0, 24'd0, 16'h7FFF, 16'h7FFF, 2'd0);
        push_frame(8388607, -8388608);
        push_frame(12345, -54321);
        drain();

        // Random phases; one long receiver hold fills the block
        for (int ph = 0; ph < 9; ph++) begin
            write_all(ph == 4 ? 1'b0 : 1'b1, pick_gain(), pick_gain(),
                      pick_amount(), pick_amount(), 2'($urandom_range(0, 3)));
            burst_mode = (ph % 3 == 2);
            if (ph == 1) hold_request = 3000;
            random_frames(200);
            drain();
        end

        repeat (400) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
hdl/tse_pkg.sv
hdl/tse_cfg.sv
hdl/tse_div.sv
hdl/tse_ctrl.sv
hdl/tse_dp.sv
hdl/transient_shaper_envelope_gain.sv
tb/tb.sv
